// ----- hw/rtl/pcbd_pkg.sv -----
// Shared types and constants for the pulse-count backlight dimmer.
// Transaction payload structs, action and register-index codes, reset values.
// No dependencies.
package pcbd_pkg;

  // Default number of brightness levels of the LED driver
  localparam int NUM_LEVELS_DEF = 32;

  localparam int BRIGHT_W = 15;
  localparam int TICKS_W  = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = TICKS_W;

  localparam logic [BRIGHT_W-1:0] MAX_BRIGHTNESS_RST = 15'd255;

  // Result actions
  typedef enum logic [1:0] {
    ACT_OFF   = 2'd0,
    ACT_ON    = 2'd1,
    ACT_PULSE = 2'd2,
    ACT_HOLD  = 2'd3
  } action_t;

  // Input commands
  typedef enum logic {
    CMD_TABLE_WRITE = 1'b0,
    CMD_REQUEST     = 1'b1
  } command_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BRIGHTNESS   = 3'd0,
    CFG_PULSE_LOW_TICKS  = 3'd1,
    CFG_PULSE_HIGH_TICKS = 3'd2,
    CFG_STARTUP_TICKS    = 3'd3,
    CFG_OFF_TICKS        = 3'd4,
    CFG_PIN_INVERT       = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic                command;
    logic [4:0]          table_index;
    logic [BRIGHT_W-1:0] table_value;
    logic signed [15:0]  requested_brightness;
    logic                power_on;
    logic                unblanked;
  } in_item_t;

  typedef struct packed {
    action_t             action;
    logic [5:0]          level_after;
    logic                end_level;
    logic [BRIGHT_W-1:0] stored_brightness;
    logic                last;
  } out_item_t;

endpackage

// ----- hw/rtl/pulse_count_backlight_dimmer.sv -----
// A request is accepted, then the table is scanned from the top level down (one table
// entry compared per cycle through the single threshold comparator), then results follow
// one per cycle while the output is taken.
// A table write gives no result. One item is worked at a time.
// Reset (synchronous, rst_n low) clears level, kept brightness and every table entry
// at once through per-entry valid bits; no clearing pass is needed.
// Depends on pcbd_pkg.
module pulse_count_backlight_dimmer
  import pcbd_pkg::*;
#(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LW = $clog2(NUM_LEVELS + 1);
  localparam int AW = $clog2(NUM_LEVELS);
  localparam logic [LW-1:0] TOP_LVL = LW'(NUM_LEVELS);
  localparam logic [AW-1:0] TOP_ADDR = AW'(NUM_LEVELS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic [LW-1:0]         cur_lvl_r, cur_lvl_nxt;
  logic [BRIGHT_W-1:0]   kept_r, kept_nxt;
  logic [BRIGHT_W-1:0]   req_r, req_nxt;
  logic [LW-1:0]         scan_lvl_r, scan_lvl_nxt;
  logic [LW-1:0]         target_r, target_nxt;
  logic [LW-1:0]         walk_lvl_r, walk_lvl_nxt;
  logic [BRIGHT_W-1:0]   max_bright_r;
  logic                  pin_inv_r;

  // Threshold store with per-entry valid bits
  logic [BRIGHT_W-1:0]   thr_mem [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] thr_vld_r;
  logic [AW-1:0]         rd_addr;
  logic [BRIGHT_W-1:0]   rd_data_r;
  logic                  rd_vld_r;

  logic                  in_fire;
  logic                  tbl_wr;
  logic [BRIGHT_W-1:0]   thr;
  logic                  hit;
  logic                  slot_free;
  logic [LW-1:0]         step_lvl;
  logic                  step_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign tbl_wr    = in_fire && (in_data.command == CMD_TABLE_WRITE)
                     && (32'(in_data.table_index) < NUM_LEVELS);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes; the tick register indexes are ignored here and change no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bright_r <= MAX_BRIGHTNESS_RST;
      pin_inv_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAX_BRIGHTNESS: max_bright_r <= cfg_wdata[BRIGHT_W-1:0];
        CFG_PIN_INVERT:     pin_inv_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Table write port and registered read port
  assign rd_addr = (state_r == ST_IDLE) ? TOP_ADDR : AW'(scan_lvl_r - LW'(2));

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      thr_mem[AW'(in_data.table_index)] <= in_data.table_value;
    end
    rd_data_r <= thr_mem[rd_addr];
    rd_vld_r  <= thr_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_vld_r <= '0;
    end else if (tbl_wr) begin
      thr_vld_r[AW'(in_data.table_index)] <= 1'b1;
    end
  end

  // Shared threshold compare
  assign thr = rd_vld_r ? rd_data_r : '0;
  assign hit = (req_r > thr);

  // Next level of the dimming walk: switch-on starts at the top, pulses wrap
  assign step_lvl  = (walk_lvl_r <= LW'(1)) ? TOP_LVL : walk_lvl_r - LW'(1);
  assign step_last = (step_lvl == target_r);
  assign slot_free = ~out_valid_r | out_ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    cur_lvl_nxt   = cur_lvl_r;
    kept_nxt      = kept_r;
    req_nxt       = req_r;
    scan_lvl_nxt  = scan_lvl_r;
    target_nxt    = target_r;
    walk_lvl_nxt  = walk_lvl_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.command == CMD_REQUEST)) begin
          // Blanking and clamping of the request
          if (!in_data.power_on || !in_data.unblanked || in_data.requested_brightness[15]) begin
            req_nxt = '0;
          end else if (in_data.requested_brightness[BRIGHT_W-1:0] > max_bright_r) begin
            req_nxt = max_bright_r;
          end else begin
            req_nxt = in_data.requested_brightness[BRIGHT_W-1:0];
          end
          scan_lvl_nxt = TOP_LVL;
          walk_lvl_nxt = cur_lvl_r;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // One entry per cycle from the top level down
        if (hit) begin
          target_nxt = scan_lvl_r;
          state_nxt  = ST_EMIT;
        end else if (scan_lvl_r == LW'(1)) begin
          target_nxt = '0;
          state_nxt  = ST_EMIT;
        end else begin
          scan_lvl_nxt = scan_lvl_r - LW'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (target_r == cur_lvl_r) begin
            out_data_nxt.action            = ACT_HOLD;
            out_data_nxt.level_after       = 6'(cur_lvl_r);
            out_data_nxt.end_level         = (cur_lvl_r != '0) ^ pin_inv_r;
            out_data_nxt.stored_brightness = kept_r;
            out_data_nxt.last              = 1'b1;
            state_nxt                      = ST_IDLE;
          end else if (target_r == '0) begin
            out_data_nxt.action            = ACT_OFF;
            out_data_nxt.level_after       = '0;
            out_data_nxt.end_level         = pin_inv_r;
            out_data_nxt.stored_brightness = req_r;
            out_data_nxt.last              = 1'b1;
            kept_nxt                       = req_r;
            cur_lvl_nxt                    = '0;
            state_nxt                      = ST_IDLE;
          end else begin
            out_data_nxt.action            = (walk_lvl_r == '0) ? ACT_ON : ACT_PULSE;
            out_data_nxt.level_after       = 6'(step_lvl);
            out_data_nxt.end_level         = ~pin_inv_r;
            out_data_nxt.stored_brightness = req_r;
            out_data_nxt.last              = step_last;
            kept_nxt                       = req_r;
            walk_lvl_nxt                   = step_lvl;
            if (step_last) begin
              cur_lvl_nxt = target_r;
              state_nxt   = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_lvl_r   <= '0;
      kept_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_lvl_r   <= cur_lvl_nxt;
      kept_r      <= kept_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    req_r      <= req_nxt;
    scan_lvl_r <= scan_lvl_nxt;
    target_r   <= target_nxt;
    walk_lvl_r <= walk_lvl_nxt;
  end

endmodule

// ----- bench/pulse_count_backlight_dimmer_tb.sv -----
// Self-checking bench for the pulse-count backlight dimmer: directed and random
// table loads and brightness requests, checked against an in-bench predictor.
// Depends on pcbd_pkg and the pulse_count_backlight_dimmer RTL.
module pulse_count_backlight_dimmer_tb;
  import pcbd_pkg::*;

  localparam int LEVELS         = NUM_LEVELS_DEF;
  localparam int IDX_W          = $clog2(LEVELS);
  localparam int CLK_PERIOD     = 12;
  localparam int SETTLE_CYCLES  = 40;      // a full scan plus margin
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int IDLE_PCT       = 28;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Bench state
  in_item_t  pending_items[$];
  out_item_t expected_actions[$];
  bit        steady = 1'b0;          // no idling on either side while set
  int        mismatches = 0;
  int        n_writes = 0;
  int        n_requests = 0;
  int        n_actions = 0;
  logic signed [15:0] last_request = '0;

  // Predictor state, mirrors the block
  logic [BRIGHT_W-1:0] thresholds [LEVELS];
  int                  led_level = 0;
  logic [BRIGHT_W-1:0] held_brightness = '0;
  logic [BRIGHT_W-1:0] clamp_max = MAX_BRIGHTNESS_RST;
  bit                  pin_flip = 1'b0;

  pulse_count_backlight_dimmer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < LEVELS; i++) thresholds[IDX_W'(i)] = '0;
  end

  // Expected result of one action; pin level is the logical level after pin_flip
  function automatic void queue_action(action_t act, int lvl, bit high,
                                       logic [BRIGHT_W-1:0] stored, bit fin);
    out_item_t r;
    r.action            = act;
    r.level_after       = lvl[5:0];
    r.end_level         = high ^ pin_flip;
    r.stored_brightness = stored;
    r.last              = fin;
    expected_actions.push_back(r);
  endfunction

  // Predict the actions caused by one accepted transaction
  function automatic void predict_dimming(in_item_t it);
    logic [BRIGHT_W-1:0] req;
    int target;
    int lvl;
    if (it.command == CMD_TABLE_WRITE) begin
      thresholds[it.table_index] = it.table_value;
      return;
    end
    // blanked, powered down or negative means zero, then clamp
    if (!it.power_on || !it.unblanked || it.requested_brightness[15])
      req = '0;
    else if (it.requested_brightness[14:0] > clamp_max)
      req = clamp_max;
    else
      req = it.requested_brightness[14:0];
    // highest level whose threshold the request exceeds
    target = LEVELS;
    while (target > 0 && req <= thresholds[IDX_W'(target-1)]) target--;
    if (target == led_level) begin
      queue_action(ACT_HOLD, led_level, led_level != 0, held_brightness, 1'b1);
      return;
    end
    held_brightness = req;
    if (target == 0) begin
      led_level = 0;
      queue_action(ACT_OFF, 0, 1'b0, req, 1'b1);
      return;
    end
    lvl = led_level;
    if (lvl == 0) begin
      lvl = LEVELS;
      queue_action(ACT_ON, lvl, 1'b1, req, lvl == target);
    end
    // each pulse steps down one level, level 1 wraps to the top
    while (lvl != target) begin
      lvl = (lvl <= 1) ? LEVELS : lvl - 1;
      queue_action(ACT_PULSE, lvl, 1'b1, req, lvl == target);
    end
    led_level = target;
  endfunction

  function automatic in_item_t table_write(int idx, int val);
    in_item_t it;
    it.command              = CMD_TABLE_WRITE;
    it.table_index          = idx[4:0];
    it.table_value          = val[BRIGHT_W-1:0];
    // fields the block must ignore on a table write
    it.requested_brightness = 16'($urandom);
    it.power_on             = 1'($urandom);
    it.unblanked            = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t request(int val, bit pwr, bit unb);
    in_item_t it;
    it.command              = CMD_REQUEST;
    it.table_index          = 5'($urandom);
    it.table_value          = BRIGHT_W'($urandom);
    it.requested_brightness = val[15:0];
    it.power_on             = pwr;
    it.unblanked            = unb;
    return it;
  endfunction

  // Mostly requests near the table thresholds and within the clamp
  function automatic in_item_t random_item();
    logic signed [15:0] v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 22)
      return table_write($urandom_range(LEVELS - 1),
                         ($urandom_range(1) != 0) ? $urandom_range(int'(clamp_max))
                                                  : $urandom);
    if (pick < 50)
      v = 16'(int'(thresholds[IDX_W'($urandom_range(LEVELS - 1))]) + $urandom_range(1));
    else if (pick < 72)
      v = 16'($urandom_range(int'(clamp_max) + 1));
    else if (pick < 86)
      v = 16'($urandom);
    else
      v = last_request;
    last_request = v;
    return request(v, $urandom_range(99) < 88, $urandom_range(99) < 88);
  endfunction

  // Monotone threshold table scaled to the current clamp
  task automatic queue_ramp();
    int base;
    int step;
    int val;
    base = $urandom_range(int'(clamp_max) / 8);
    step = $urandom_range(int'(clamp_max) / 32 + 1, 1);
    for (int i = 0; i < LEVELS; i++) begin
      val = base + i * step;
      pending_items.push_back(table_write(i, (val > 32767) ? 32767 : val));
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MAX_BRIGHTNESS: clamp_max = val[BRIGHT_W-1:0];
      CFG_PIN_INVERT:     pin_flip  = val[0];
      default: ;          // tick counts change no action
    endcase
  endtask

  // Sampled on the falling edge so that every update of the rising edge is seen
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_actions.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [BRIGHT_W-1:0] max_b,
                           input logic [TICKS_W-1:0] low_t, input logic [TICKS_W-1:0] high_t,
                           input logic [TICKS_W-1:0] start_t, input logic [TICKS_W-1:0] off_t,
                           input bit inv, input bit ramp, input int n_items, input bit calm);
    write_reg(CFG_MAX_BRIGHTNESS, CFG_DATA_W'(max_b));
    write_reg(CFG_PULSE_LOW_TICKS, low_t);
    write_reg(CFG_PULSE_HIGH_TICKS, high_t);
    write_reg(CFG_STARTUP_TICKS, start_t);
    write_reg(CFG_OFF_TICKS, off_t);
    write_reg(CFG_PIN_INVERT, CFG_DATA_W'(inv));
    steady = calm;
    if (ramp) queue_ramp();
    for (int k = 0; k < n_items; k++) begin
      pending_items.push_back(random_item());
      // hold the sender mid-phase until every expected action is back
      if (k == n_items / 2) wait_drained();
    end
    wait_drained();
    steady = 1'b0;
  endtask

  // Driver: next pending transaction once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_dimming(in_data);
        if (in_data.command == CMD_TABLE_WRITE) n_writes++;
        else n_requests++;
      end
      if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted action with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_actions++;
      if (expected_actions.size() == 0) begin
        report_mismatch($sformatf("unexpected action %0d level %0d",
                                  out_data.action, out_data.level_after));
      end else begin
        want = expected_actions.pop_front();
        if (out_data.action !== want.action)
          report_mismatch($sformatf("action %0d, want %0d", out_data.action, want.action));
        if (out_data.level_after !== want.level_after)
          report_mismatch($sformatf("level_after %0d, want %0d",
                                    out_data.level_after, want.level_after));
        if (out_data.end_level !== want.end_level)
          report_mismatch($sformatf("end_level %0b, want %0b",
                                    out_data.end_level, want.end_level));
        if (out_data.stored_brightness !== want.stored_brightness)
          report_mismatch($sformatf("stored_brightness %0d, want %0d",
                                    out_data.stored_brightness, want.stored_brightness));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_data.last, want.last));
      end
    end
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Stimulus
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, zeroed table
    pending_items.push_back(request(100, 1'b1, 1'b1));      // switch on at the top level
    pending_items.push_back(request(100, 1'b1, 1'b1));      // no change
    pending_items.push_back(request(0, 1'b1, 1'b1));        // switch off
    pending_items.push_back(request(-32768, 1'b1, 1'b1));   // negative, stays off
    pending_items.push_back(request(32767, 1'b0, 1'b1));    // powered down
    pending_items.push_back(request(32767, 1'b1, 1'b0));    // blanked
    pending_items.push_back(request(32767, 1'b1, 1'b1));    // clamped to max
    pending_items.push_back(table_write(31, 32767));
    pending_items.push_back(table_write(30, 200));
    pending_items.push_back(request(150, 1'b1, 1'b1));      // two pulses down
    pending_items.push_back(request(250, 1'b1, 1'b1));      // upward move wraps through 1
    pending_items.push_back(table_write(0, 0));
    pending_items.push_back(request(32767, 1'b1, 1'b1));    // same level, kept value
    pending_items.push_back(request(200, 1'b1, 1'b1));      // equal to threshold
    pending_items.push_back(request(-1, 1'b1, 1'b1));
    pending_items.push_back(request(1, 1'b1, 1'b1));        // on, then pulses
    pending_items.push_back(table_write(15, 21845));
    pending_items.push_back(table_write(16, 10922));
    pending_items.push_back(request(16'h5555, 1'b1, 1'b1));
    pending_items.push_back(request(16'hAAAA, 1'b1, 1'b1));
    pending_items.push_back(request(0, 1'b0, 1'b0));
    wait_drained();

    // Random phases across register settings, extremes first
    run_phase(15'h7FFF, 20'd1, 20'd1, 20'd1, 20'd1, 1'b1, 1'b1, 6, 1'b0);
    run_phase(15'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0, 1'b0, 8, 1'b0);
    run_phase(BRIGHT_W'($urandom_range(32767, 1)), TICKS_W'($urandom_range(20'hFFFFF, 1)),
              TICKS_W'($urandom_range(20'hFFFFF, 1)), TICKS_W'($urandom_range(20'hFFFFF, 1)),
              TICKS_W'($urandom_range(20'hFFFFF, 1)), 1'($urandom_range(1)), 1'b1, 10, 1'b1);
    run_phase(MAX_BRIGHTNESS_RST, 20'd21, 20'd21, 20'd100000, 20'd300000,
              1'b1, 1'b0, 12, 1'b0);

    $display("Covered %0d table writes and %0d brightness requests, %0d actions checked,",
             n_writes, n_requests, n_actions);
    $display("over clamp values 0, 255, full scale and random, with both pin polarities.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timeout with %0d actions outstanding", expected_actions.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pcbd_pkg.sv
hw/rtl/pulse_count_backlight_dimmer.sv
bench/pulse_count_backlight_dimmer_tb.sv
